@@ hdl/cws_pkg.sv @@
// cws_pkg: shared constants and the byte-wide crc-32c step
// used by cws_fold and crc32c_word_stream; no dependencies

package cws_pkg;

	// reflected castagnoli polynomial
	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	// reset value of the initial-value register and the running crc
	localparam logic [31:0] INIT_RESET = 32'hDEBB_20E3;
	// bytes in one data word
	localparam int unsigned WORD_BYTES = 8;
	// largest meaningful byte count
	localparam logic [3:0] COUNT_MAX = 4'd8;

	// one byte folded into the reflected crc, lsb first
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] din);
		logic [31:0] c;
		c = crc_in ^ {24'd0, din};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ hdl/crc32c_word_stream.sv @@
// crc32c_word_stream: reflected crc-32c over a stream of 64-bit words
// depends on cws_pkg and cws_fold
//
//  channel | signals                                   | dir | beat when
//  --------+-------------------------------------------+-----+----------------------
//  in      | in_valid in_ready data_word byte_count    | in  | in_valid & in_ready
//          | last_word                                 |     |
//  out     | out_valid out_ready crc_out               | out | out_valid & out_ready
//  cfg     | cfg_wr_en cfg_wr_data                     | in  | cfg_wr_en
//
// one word per cycle while no last word waits on a held result; a word is captured
// in the stage-1 register, other words are folded from there into the running crc,
// and a last word's crc goes to the output register as it leaves stage 1
// the fold is a combinational xor network over eight byte lanes
// reset loads 0xdebb20e3 into the initial value and the running crc
// a held result stalls only a last word; other words keep flowing

module crc32c_word_stream import cws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] crc_out,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	logic [31:0] init_q;
	logic [31:0] run_crc_q;
	logic        valid_s1;
	logic [63:0] data_s1;
	logic [3:0]  count_s1;
	logic        last_s1;
	logic        out_valid_q;
	logic [31:0] crc_out_q;
	logic [31:0] crc_next;
	logic        adv_s1;
	logic [3:0]  count_sat;

	// a last word needs a free result slot, other words always move on
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// clamp counts above eight
	always_comb begin
		if (byte_count inside {[4'd9:4'd15]}) begin
			count_sat = COUNT_MAX;
		end else begin
			count_sat = byte_count;
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_word;
			count_s1 <= count_sat;
			last_s1  <= last_word;
		end
	end

	// byte fold
	cws_fold u_fold (
		.crc_in     (run_crc_q),
		.data_word  (data_s1),
		.byte_count (count_s1),
		.crc_next   (crc_next)
	);

	// initial value and running crc; a config write restarts the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= INIT_RESET;
			run_crc_q <= INIT_RESET;
		end else if (cfg_wr_en) begin
			init_q    <= cfg_wr_data;
			run_crc_q <= cfg_wr_data;
		end else if (adv_s1) begin
			run_crc_q <= last_s1 ? init_q : crc_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			crc_out_q <= crc_next;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_out   = crc_out_q;

	// checks

	// the only stall is a last word behind an unaccepted result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && last_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a held result");

	// a finished buffer shows its crc at the next edge
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (out_valid && crc_out == $past(crc_next)))
		else $error("result not loaded after last word");

	// running crc restarts from the initial value after a buffer
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1 && !cfg_wr_en) |=> (run_crc_q == init_q))
		else $error("running crc not reloaded after last word");

	// a config write reloads the running crc
	a_cfg_reload: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> (run_crc_q == $past(cfg_wr_data) && init_q == $past(cfg_wr_data)))
		else $error("config write did not reload running crc");

endmodule

@@ hdl/cws_fold.sv @@
// cws_fold: xor network that folds up to eight bytes of a word into a crc
// depends on cws_pkg

module cws_fold import cws_pkg::*; (
	input  logic [31:0] crc_in,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	output logic [31:0] crc_next
);

	// byte lanes in order; lanes at or above the count pass the crc unchanged
	always_comb begin
		logic [31:0] c;
		c = crc_in;
		for (int i = 0; i < WORD_BYTES; i++) begin
			if (4'(i) < byte_count) begin
				c = crc_byte(c, data_word[8*i +: 8]);
			end
		end
		crc_next = c;
	end

endmodule
